// File: src/text_console_char_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;
    localparam int PROD_W  = COL_W + ROW_W;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

    // Control characters and drawn glyphs
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
    localparam logic [CHAR_W-1:0] CH_BLOCK     = 8'd219;
    localparam logic [COL_W:0]    TAB_STEP     = 8'd4;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_BLINK = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] line;
        logic             blink_on;
    } t_cursor;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [CELL_W-1:0] cell_value;
    } t_cell_write;

endpackage

// File: src/tcw_step.sv
module tcw_step (
    input  tcw_pkg::t_cursor                i_cur,
    input  logic [1:0]                      i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]       i_new_column,
    input  logic [tcw_pkg::ROW_W-1:0]       i_new_row,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_text_color,
    output tcw_pkg::t_cursor                o_cur,
    output tcw_pkg::t_cell_write            o_wr
);
    import tcw_pkg::*;

    t_opcode          op;
    logic [COL_W:0]   col_inc;
    logic [COL_W:0]   col_tab;
    logic [ROW_W:0]   line_inc;
    logic [COL_W-1:0] col_back;
    logic [COL_W-1:0] w_col;
    logic [CHAR_W-1:0] w_char;
    logic             w_en;
    logic [PROD_W-1:0] addr_full;

    assign op       = t_opcode'(i_opcode);
    assign col_inc  = {1'b0, i_cur.column} + (COL_W+1)'(1);
    assign col_tab  = {1'b0, i_cur.column} + TAB_STEP;
    assign line_inc = {1'b0, i_cur.line} + (ROW_W+1)'(1);
    assign col_back = (i_cur.column != '0) ? i_cur.column - COL_W'(1) : '0;

    always_comb begin
        o_cur  = i_cur;
        w_en   = 1'b0;
        w_col  = i_cur.column;
        w_char = CH_BLANK;
        unique case (op)
            OP_PUT: begin
                priority if (i_char_code == CH_NEWLINE) begin
                    w_en         = 1'b1;
                    o_cur.column = '0;
                    o_cur.line   = (line_inc >= (ROW_W+1)'(ROWS)) ? '0
                                                                 : line_inc[ROW_W-1:0];
                end else if (i_char_code == CH_RETURN) begin
                    o_cur.column = '0;
                end else if (i_char_code == CH_BACKSPACE) begin
                    w_en         = 1'b1;
                    w_col        = col_back;
                    o_cur.column = col_back;
                end else if (i_char_code == CH_TAB) begin
                    o_cur.column = (col_tab >= (COL_W+1)'(COLUMNS)) ? '0
                                                                    : col_tab[COL_W-1:0];
                end else begin
                    w_en         = 1'b1;
                    w_char       = i_char_code;
                    o_cur.column = (col_inc >= (COL_W+1)'(COLUMNS)) ? '0
                                                                    : col_inc[COL_W-1:0];
                end
            end
            OP_SET: begin
                o_cur.column = (i_new_column >= COL_W'(COLUMNS)) ? '0 : i_new_column;
                o_cur.line   = (i_new_row >= ROW_W'(ROWS)) ? '0 : i_new_row;
            end
            OP_BLINK: begin
                w_en           = 1'b1;
                o_cur.blink_on = ~i_cur.blink_on;
                w_char         = i_cur.blink_on ? CH_BLOCK : CH_BLANK;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Line stays at the pre-item value for every write
    assign addr_full = PROD_W'(i_cur.line) * PROD_W'(COLUMNS) + PROD_W'(w_col);

    always_comb begin
        o_wr = '0;
        if (w_en) begin
            o_wr.write_enable  = 1'b1;
            o_wr.write_address = addr_full[ADDR_W-1:0];
            o_wr.cell_value    = {i_text_color, w_char};
        end
    end

endmodule

// File: src/text_console_char_writer.sv
// An accepted input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless i_out_stall holds a result; the cursor add, wrap
// and the row*COLUMNS address multiply by a constant fit between the input register and result register.
// Reset (i_rst_n low, synchronous): cursor to column 0 / row 0, blink flag set,
// text color 7, both pipeline registers emptied.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: text color attribute
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]       i_new_column,
    input  logic [tcw_pkg::ROW_W-1:0]       i_new_row,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_write_enable,
    output logic [tcw_pkg::ADDR_W-1:0]      o_write_address,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_value,
    output logic [tcw_pkg::COL_W-1:0]       o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]       o_cursor_row
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] r_color;

    // Input register
    logic               r_in_valid;
    logic [1:0]         r_opcode;
    logic [CHAR_W-1:0]  r_char_code;
    logic [COL_W-1:0]   r_new_column;
    logic [ROW_W-1:0]   r_new_row;

    // Cursor state, advanced only when an item moves into the result register
    t_cursor            r_cur;
    t_cursor            n_cur;
    t_cell_write        n_wr;

    // Result register
    logic               r_out_valid;
    t_cell_write        r_wr;
    logic [COL_W-1:0]   r_out_column;
    logic [ROW_W-1:0]   r_out_row;

    logic               out_free;
    logic               s1_adv;
    logic               in_acc;

    // Result register can load when empty or when its transaction leaves now
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    // Input register: hold while the result side is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode     <= i_opcode;
            r_char_code  <= i_char_code;
            r_new_column <= i_new_column;
            r_new_row    <= i_new_row;
        end
    end

    tcw_step u_step (
        .i_cur        (r_cur),
        .i_opcode     (r_opcode),
        .i_char_code  (r_char_code),
        .i_new_column (r_new_column),
        .i_new_row    (r_new_row),
        .i_text_color (r_color),
        .o_cur        (n_cur),
        .o_wr         (n_wr)
    );

    // Cursor state and result register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.column   <= '0;
            r_cur.line     <= '0;
            r_cur.blink_on <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_cur <= n_cur;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wr         <= n_wr;
            r_out_column <= n_cur.column;
            r_out_row    <= n_cur.line;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_enable  = r_wr.write_enable;
    assign o_write_address = r_wr.write_address;
    assign o_cell_value    = r_wr.cell_value;
    assign o_cursor_column = r_out_column;
    assign o_cursor_row    = r_out_row;

    // Cursor never leaves the screen
    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, 1'b1, (r_cur.column < COL_W'(COLUMNS)) && (r_cur.line < ROW_W'(ROWS)))
    // A held result reports the cursor that the state now holds
    `TCW_ASSERT_IMP(a_out_matches_state, i_clk, i_rst_n, r_out_valid, (r_out_column == r_cur.column) && (r_out_row == r_cur.line))
    // No write means zero address and cell
    `TCW_ASSERT_IMP(a_idle_write_zero, i_clk, i_rst_n, r_out_valid && !r_wr.write_enable, (r_wr.write_address == '0) && (r_wr.cell_value == '0))
    // An item leaving the input register shows up as a result
    `TCW_ASSERT_NXT(a_stage_moves, i_clk, i_rst_n, s1_adv, r_out_valid)

endmodule
